### hdl/ocm_pkg.sv
package ocm_pkg;

	localparam int LoadW    = 24;
	localparam int RatioW   = 12;
	localparam int TickW    = 8;
	localparam int FracW    = 10;
	localparam int CntW     = 8;
	localparam int CmpW     = (CntW > TickW) ? CntW : TickW;
	localparam int ProdW    = LoadW + RatioW + 1;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 24;

	typedef enum logic [CfgIdxW-1:0] {
		REG_INSTANT_RATIO = 3'd0,
		REG_INSTANT_TICKS = 3'd1,
		REG_CONTROL_RATIO = 3'd2,
		REG_CONTROL_TICKS = 3'd3,
		REG_ALARM_RATIO   = 3'd4,
		REG_SLOW_WEIGHT   = 3'd5,
		REG_SLOW_TICKS    = 3'd6
	} cfg_idx_t;

	localparam logic [RatioW-1:0] InstantRatioRst = 12'd1024;
	localparam logic [TickW-1:0]  InstantTicksRst = 8'd1;
	localparam logic [RatioW-1:0] ControlRatioRst = 12'd1024;
	localparam logic [TickW-1:0]  ControlTicksRst = 8'd1;
	localparam logic [RatioW-1:0] AlarmRatioRst   = 12'd922;
	localparam logic [LoadW-1:0]  SlowWeightRst   = 24'd0;
	localparam logic [TickW-1:0]  SlowTicksRst    = 8'd1;

	typedef struct packed {
		logic [RatioW-1:0]       instant_ratio;
		logic [TickW-1:0]        instant_ticks;
		logic [RatioW-1:0]       control_ratio;
		logic [TickW-1:0]        control_ticks;
		logic [RatioW-1:0]       alarm_ratio;
		logic signed [LoadW-1:0] slow_weight;
		logic [TickW-1:0]        slow_ticks;
	} cfg_t;

	typedef struct packed {
		logic inst;
		logic ctrl;
		logic alarm;
		logic slow;
	} cmp_t;

	typedef logic [CntW-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t c);
		return (c == {CntW{1'b1}}) ? c : c + CntW'(1);
	endfunction

endpackage

### hdl/ocm_ifs.sv
interface ocm_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [ocm_pkg::LoadW-1:0] gross_load;
	logic signed [ocm_pkg::LoadW-1:0] rated_load;

	modport source(output valid, gross_load, rated_load, input ready);
	modport sink(input valid, gross_load, rated_load, output ready);
endinterface

interface ocm_out_if;
	logic valid;
	logic ready;
	logic cutoff;
	logic slowdown;
	logic alarm;

	modport source(output valid, cutoff, slowdown, alarm, input ready);
	modport sink(input valid, cutoff, slowdown, alarm, output ready);
endinterface

interface ocm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ocm_pkg::CfgIdxW-1:0]    index;
	logic [ocm_pkg::CfgDataW-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### hdl/ocm_cfg_regs.sv
module ocm_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	ocm_cfg_if.sink        cfg,
	output ocm_pkg::cfg_t  regs
);

	ocm_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.instant_ratio <= ocm_pkg::InstantRatioRst;
			regs_q.instant_ticks <= ocm_pkg::InstantTicksRst;
			regs_q.control_ratio <= ocm_pkg::ControlRatioRst;
			regs_q.control_ticks <= ocm_pkg::ControlTicksRst;
			regs_q.alarm_ratio   <= ocm_pkg::AlarmRatioRst;
			regs_q.slow_weight   <= ocm_pkg::SlowWeightRst;
			regs_q.slow_ticks    <= ocm_pkg::SlowTicksRst;
		end else if (cfg.valid && cfg.ready) begin
			unique case (ocm_pkg::cfg_idx_t'(cfg.index))
				ocm_pkg::REG_INSTANT_RATIO: regs_q.instant_ratio <= cfg.data[ocm_pkg::RatioW-1:0];
				ocm_pkg::REG_INSTANT_TICKS: regs_q.instant_ticks <= cfg.data[ocm_pkg::TickW-1:0];
				ocm_pkg::REG_CONTROL_RATIO: regs_q.control_ratio <= cfg.data[ocm_pkg::RatioW-1:0];
				ocm_pkg::REG_CONTROL_TICKS: regs_q.control_ticks <= cfg.data[ocm_pkg::TickW-1:0];
				ocm_pkg::REG_ALARM_RATIO:   regs_q.alarm_ratio   <= cfg.data[ocm_pkg::RatioW-1:0];
				ocm_pkg::REG_SLOW_WEIGHT:   regs_q.slow_weight   <= $signed(cfg.data[ocm_pkg::LoadW-1:0]);
				ocm_pkg::REG_SLOW_TICKS:    regs_q.slow_ticks    <= cfg.data[ocm_pkg::TickW-1:0];
				default: ;
			endcase
		end
	end

endmodule

### hdl/ocm_limit_pipe.sv
module ocm_limit_pipe (
	input  logic           clk,
	input  logic           arst_n,
	ocm_in_if.sink         sample,
	input  ocm_pkg::cfg_t  regs,
	input  logic           cmp_ready,
	output logic           cmp_valid,
	output ocm_pkg::cmp_t  cmp
);

	localparam int ExtW = ocm_pkg::ProdW - ocm_pkg::LoadW - ocm_pkg::FracW;

	logic                                v_s1;
	logic                                rdy1;
	logic signed [ocm_pkg::LoadW-1:0]   gross_s1, rated_s1;
	logic signed [ocm_pkg::ProdW-1:0]   prod_i, prod_c, prod_a;
	logic signed [ocm_pkg::ProdW-1:0]   gross_sc;

	assign rdy1         = !v_s1 || cmp_ready;
	assign sample.ready = rdy1;
	assign cmp_valid    = v_s1;

	assign prod_i = rated_s1 * $signed({1'b0, regs.instant_ratio});
	assign prod_c = rated_s1 * $signed({1'b0, regs.control_ratio});
	assign prod_a = rated_s1 * $signed({1'b0, regs.alarm_ratio});

	assign gross_sc = {{ExtW{gross_s1[ocm_pkg::LoadW-1]}}, gross_s1, {ocm_pkg::FracW{1'b0}}};

	always_comb begin
		cmp.inst  = gross_sc > prod_i;
		cmp.ctrl  = gross_sc > prod_c;
		cmp.alarm = gross_sc > prod_a;
		cmp.slow  = gross_s1 > $signed(regs.slow_weight);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= sample.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && rdy1) begin
			gross_s1 <= sample.gross_load;
			rated_s1 <= sample.rated_load;
		end
	end

endmodule

### hdl/ocm_flag_state.sv
module ocm_flag_state (
	input  logic           clk,
	input  logic           arst_n,
	input  ocm_pkg::cfg_t  regs,
	input  logic           cmp_valid,
	input  ocm_pkg::cmp_t  cmp,
	output logic           cmp_ready,
	ocm_out_if.source      result
);

	logic          out_valid_q;
	logic          cutoff_q, slow_q, alarm_q;
	logic          cutoff_d, slow_d;
	ocm_pkg::cnt_t inst_cnt_q, ctrl_cnt_q, slow_cnt_q;
	ocm_pkg::cnt_t inst_cnt_d, ctrl_cnt_d, slow_cnt_d;
	logic          ld;

	assign cmp_ready       = !out_valid_q || result.ready;
	assign ld              = cmp_valid && cmp_ready;
	assign result.valid    = out_valid_q;
	assign result.cutoff   = cutoff_q;
	assign result.slowdown = slow_q;
	assign result.alarm    = alarm_q;

	always_comb begin
		cutoff_d   = cutoff_q;
		slow_d     = slow_q;
		inst_cnt_d = '0;
		ctrl_cnt_d = '0;
		slow_cnt_d = '0;

		if (cmp.inst) begin
			inst_cnt_d = ocm_pkg::sat_inc(inst_cnt_q);
			if (ocm_pkg::CmpW'(inst_cnt_d) >= ocm_pkg::CmpW'(regs.instant_ticks)) begin
				cutoff_d = 1'b1;
			end
		end

		if (cmp.ctrl) begin
			ctrl_cnt_d = ocm_pkg::sat_inc(ctrl_cnt_q);
			if (ocm_pkg::CmpW'(ctrl_cnt_d) >= ocm_pkg::CmpW'(regs.control_ticks)) begin
				cutoff_d = 1'b1;
			end
		end else begin
			cutoff_d   = 1'b0;
			inst_cnt_d = '0;
		end

		if (cmp.slow) begin
			slow_cnt_d = ocm_pkg::sat_inc(slow_cnt_q);
			if (ocm_pkg::CmpW'(slow_cnt_d) > ocm_pkg::CmpW'(regs.slow_ticks)) begin
				slow_d = 1'b1;
			end
		end else begin
			slow_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cutoff_q    <= 1'b0;
			slow_q      <= 1'b0;
			alarm_q     <= 1'b0;
			inst_cnt_q  <= '0;
			ctrl_cnt_q  <= '0;
			slow_cnt_q  <= '0;
		end else begin
			if (ld) begin
				out_valid_q <= 1'b1;
				cutoff_q    <= cutoff_d;
				slow_q      <= slow_d;
				alarm_q     <= cmp.alarm;
				inst_cnt_q  <= inst_cnt_d;
				ctrl_cnt_q  <= ctrl_cnt_d;
				slow_cnt_q  <= slow_cnt_d;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/overload_cutoff_monitor.sv
// Overload cutoff monitor: takes one load sample per clock and returns one flag
// set (cutoff, slowdown, alarm) per sample, in order. The accepting edge loads the
// input register; the three limit products and compares and the counter and sticky
// flag update are combinational, and the result register loads from them once the
// output side can take a new result. A stalled result
// holds the input register, which then holds off the next request. The three
// limits are exact signed compares of gross * 1024 against rated * ratio (Q2.10).
// Configuration writes are always ready and take effect at once; write them only
// while no sample is in flight.
module overload_cutoff_monitor (
	input  logic        clk,
	input  logic        arst_n,
	ocm_in_if.sink      sample,
	ocm_out_if.source   result,
	ocm_cfg_if.sink     cfg
);

	ocm_pkg::cfg_t regs;
	ocm_pkg::cmp_t cmp;
	logic          cmp_valid;
	logic          cmp_ready;

	ocm_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ocm_limit_pipe u_limit_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.regs      (regs),
		.cmp_ready (cmp_ready),
		.cmp_valid (cmp_valid),
		.cmp       (cmp)
	);

	ocm_flag_state u_flag_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.cmp_valid (cmp_valid),
		.cmp       (cmp),
		.cmp_ready (cmp_ready),
		.result    (result)
	);

	a_cutoff_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_valid && cmp_ready && !cmp.ctrl) |=> !result.cutoff)
		else $error("cutoff held at or below control limit");

	a_alarm_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_valid && cmp_ready) |=> (result.alarm == $past(cmp.alarm)))
		else $error("alarm does not follow alarm compare");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmp_valid && cmp_ready) |=> $stable({result.cutoff, result.slowdown, result.alarm}))
		else $error("flags changed without a new request");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ocm_pkg::*;

	localparam int QuietLimit = 3000;
	localparam int HoldCycles = 300;
	localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;
	localparam logic signed [LoadW-1:0] LoadMax = {1'b0, {(LoadW-1){1'b1}}};
	localparam logic signed [LoadW-1:0] LoadMin = {1'b1, {(LoadW-1){1'b0}}};

	typedef struct packed {
		logic cutoff;
		logic slowdown;
		logic alarm;
	} flags_t;

	typedef enum int {RUN_NOISE, RUN_OVER, RUN_UNDER, RUN_MIXED} run_kind_t;

	class flag_scoreboard;
		cfg_t     setting;
		cnt_t     inst_run;
		cnt_t     ctrl_run;
		cnt_t     slow_run;
		logic     cut;
		logic     slw;
		logic     alm;
		flags_t   expected_flags[$];
		int       mismatches;

		function new();
			setting.instant_ratio = InstantRatioRst;
			setting.instant_ticks = InstantTicksRst;
			setting.control_ratio = ControlRatioRst;
			setting.control_ticks = ControlTicksRst;
			setting.alarm_ratio   = AlarmRatioRst;
			setting.slow_weight   = SlowWeightRst;
			setting.slow_ticks    = SlowTicksRst;
			inst_run = '0;
			ctrl_run = '0;
			slow_run = '0;
			cut = 1'b0;
			slw = 1'b0;
			alm = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				REG_INSTANT_RATIO: setting.instant_ratio = data[RatioW-1:0];
				REG_INSTANT_TICKS: setting.instant_ticks = data[TickW-1:0];
				REG_CONTROL_RATIO: setting.control_ratio = data[RatioW-1:0];
				REG_CONTROL_TICKS: setting.control_ticks = data[TickW-1:0];
				REG_ALARM_RATIO:   setting.alarm_ratio   = data[RatioW-1:0];
				REG_SLOW_WEIGHT:   setting.slow_weight   = data[LoadW-1:0];
				REG_SLOW_TICKS:    setting.slow_ticks    = data[TickW-1:0];
				default: ;
			endcase
		endfunction

		function bit exceeds(logic signed [LoadW-1:0] gross, logic signed [LoadW-1:0] rated,
				logic [RatioW-1:0] ratio);
			return longint'(gross) * 1024 > longint'(rated) * longint'(ratio);
		endfunction

		function cnt_t bump(cnt_t c);
			return (&c) ? c : c + 1'b1;
		endfunction

		function void note_sample(logic signed [LoadW-1:0] gross, logic signed [LoadW-1:0] rated);
			if (exceeds(gross, rated, setting.instant_ratio)) begin
				inst_run = bump(inst_run);
				if (CmpW'(inst_run) >= CmpW'(setting.instant_ticks))
					cut = 1'b1;
			end else begin
				inst_run = '0;
			end
			if (exceeds(gross, rated, setting.control_ratio)) begin
				ctrl_run = bump(ctrl_run);
				if (CmpW'(ctrl_run) >= CmpW'(setting.control_ticks))
					cut = 1'b1;
			end else begin
				cut = 1'b0;
				ctrl_run = '0;
				inst_run = '0;
			end
			alm = exceeds(gross, rated, setting.alarm_ratio);
			if (gross > setting.slow_weight) begin
				slow_run = bump(slow_run);
				if (CmpW'(slow_run) > CmpW'(setting.slow_ticks))
					slw = 1'b1;
			end else begin
				slow_run = '0;
				slw = 1'b0;
			end
			expected_flags.push_back('{cutoff: cut, slowdown: slw, alarm: alm});
		endfunction

		function void check_result(flags_t got);
			flags_t want;
			if (expected_flags.size() == 0) begin
				$display("%0t: unexpected result, expected none, got cutoff=%0b slowdown=%0b alarm=%0b",
					$time, got.cutoff, got.slowdown, got.alarm);
				mismatches++;
				return;
			end
			want = expected_flags.pop_front();
			if (want.cutoff !== got.cutoff) begin
				$display("%0t: cutoff expected %0b got %0b", $time, want.cutoff, got.cutoff);
				mismatches++;
			end
			if (want.slowdown !== got.slowdown) begin
				$display("%0t: slowdown expected %0b got %0b", $time, want.slowdown, got.slowdown);
				mismatches++;
			end
			if (want.alarm !== got.alarm) begin
				$display("%0t: alarm expected %0b got %0b", $time, want.alarm, got.alarm);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_flags.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ocm_in_if  sample_if ();
	ocm_out_if result_if ();
	ocm_cfg_if cfg_if ();

	overload_cutoff_monitor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	flag_scoreboard sb = new();
	cfg_t cur_cfg;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				sb.write_reg(cfg_if.index, cfg_if.data);
			if (sample_if.valid && sample_if.ready)
				sb.note_sample(sample_if.gross_load, sample_if.rated_load);
			if (result_if.valid && result_if.ready)
				sb.check_result('{cutoff: result_if.cutoff, slowdown: result_if.slowdown,
					alarm: result_if.alarm});
		end
	end

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_request) begin
				// hold the receiver off so the pipeline backs up
				hold_request = 1'b0;
				hold_left = HoldCycles;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send_sample(input logic signed [LoadW-1:0] gross,
			input logic signed [LoadW-1:0] rated);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_if.valid <= 1'b0;
			@(negedge clk);
		end
		sample_if.valid      <= 1'b1;
		sample_if.gross_load <= gross;
		sample_if.rated_load <= rated;
		do @(posedge clk); while (!sample_if.ready);
	endtask

	task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic apply_setting(input cfg_t s);
		write_cfg(REG_INSTANT_RATIO, CfgDataW'(s.instant_ratio));
		write_cfg(REG_INSTANT_TICKS, CfgDataW'(s.instant_ticks));
		write_cfg(REG_CONTROL_RATIO, CfgDataW'(s.control_ratio));
		write_cfg(REG_CONTROL_TICKS, CfgDataW'(s.control_ticks));
		write_cfg(REG_ALARM_RATIO, CfgDataW'(s.alarm_ratio));
		write_cfg(REG_SLOW_WEIGHT, CfgDataW'(s.slow_weight));
		write_cfg(REG_SLOW_TICKS, CfgDataW'(s.slow_ticks));
		cur_cfg = s;
	endtask

	task automatic drain();
		@(negedge clk);
		sample_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [RatioW-1:0] pick_ratio();
		case ($urandom_range(19))
			0, 1, 2: return '0;
			3, 4, 5: return '1;
			6, 7, 8, 9: return RatioW'($urandom);
			default: return RatioW'($urandom_range(700, 1400));
		endcase
	endfunction

	function automatic logic [TickW-1:0] pick_ticks();
		case ($urandom_range(19))
			0, 1, 2: return '0;
			3, 4: return '1;
			5, 6: return TickW'($urandom);
			default: return TickW'($urandom_range(1, 10));
		endcase
	endfunction

	function automatic logic signed [LoadW-1:0] pick_load();
		int v;
		case ($urandom_range(3))
			0: return LoadW'($urandom);
			1: begin
				v = $urandom_range(2000);
				return LoadW'(v - 1000);
			end
			default: return LoadW'($urandom_range(400000));
		endcase
	endfunction

	function automatic cfg_t random_setting();
		cfg_t s;
		int v;
		s.instant_ratio = pick_ratio();
		s.instant_ticks = pick_ticks();
		s.control_ratio = pick_ratio();
		s.control_ticks = pick_ticks();
		s.alarm_ratio   = pick_ratio();
		s.slow_ticks    = pick_ticks();
		case ($urandom_range(9))
			0: s.slow_weight = LoadMin;
			1: s.slow_weight = LoadMax;
			2, 3: s.slow_weight = LoadW'($urandom);
			default: begin
				v = $urandom_range(300000);
				s.slow_weight = LoadW'(v - 50000);
			end
		endcase
		return s;
	endfunction

	function automatic logic signed [LoadW-1:0] near_limit(logic signed [LoadW-1:0] rated,
			logic [RatioW-1:0] ratio, int off);
		longint v;
		v = (longint'(rated) * longint'(ratio)) >>> FracW;
		v = v + off;
		if (v > LoadMax)
			v = LoadMax;
		if (v < LoadMin)
			v = LoadMin;
		return v[LoadW-1:0];
	endfunction

	task automatic run_random(input int n);
		int left, len, off, i;
		run_kind_t kind;
		logic [RatioW-1:0] base;
		logic signed [LoadW-1:0] rated, gross;
		left = n;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
			case ($urandom_range(7))
				0: kind = RUN_NOISE;
				1, 2, 3: kind = RUN_OVER;
				4, 5: kind = RUN_UNDER;
				default: kind = RUN_MIXED;
			endcase
			case ($urandom_range(2))
				0: base = cur_cfg.instant_ratio;
				1: base = cur_cfg.control_ratio;
				default: base = cur_cfg.alarm_ratio;
			endcase
			rated = pick_load();
			for (i = 0; i < len && left > 0; i++) begin
				if ($urandom_range(9) < 3)
					rated = pick_load();
				case (kind)
					RUN_OVER: off = $urandom_range(1, 4);
					RUN_UNDER: off = -$urandom_range(0, 4);
					default: off = $urandom_range(6) - 3;
				endcase
				if (kind == RUN_NOISE)
					gross = LoadW'($urandom);
				else
					gross = near_limit(rated, base, off);
				send_sample(gross, rated);
				left--;
			end
		end
	endtask

	int src_plan [3] = '{33, 72, 0};
	int snk_plan [3] = '{72, 33, 0};

	initial begin : stimulus
		cfg_t s;
		int regime, k, i;
		logic signed [LoadW-1:0] r;

		arst_n = 1'b0;
		sample_if.valid = 1'b0;
		sample_if.gross_load = '0;
		sample_if.rated_load = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		cur_cfg = sb.setting;
		src_idle_pct = src_plan[0];
		snk_idle_pct = snk_plan[0];
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_sample(24'sd0, 24'sd0);
		send_sample(LoadMax, LoadMax);
		send_sample(LoadMax, LoadMin);
		send_sample(LoadMin, LoadMax);
		send_sample(LoadMin, LoadMin);
		send_sample(24'sd1001, 24'sd1000);
		send_sample(24'sd1001, 24'sd1000);
		send_sample(24'sd950, 24'sd1000);
		send_sample(24'sd900, 24'sd1000);
		send_sample(-24'sd5, -24'sd10);
		send_sample(-24'sd10, -24'sd5);
		send_sample(24'sd1, 24'sd0);
		drain();

		// zero instant ratio, full-scale control and alarm ratios, zero tick counts, weight at its floor
		s.instant_ratio = '0;
		s.instant_ticks = '0;
		s.control_ratio = '1;
		s.control_ticks = '0;
		s.alarm_ratio   = '1;
		s.slow_weight   = LoadMin;
		s.slow_ticks    = '0;
		apply_setting(s);
		write_cfg(RegUnmapped, '1);
		send_sample(24'sd1, 24'sd1);
		send_sample(24'sd5000, 24'sd1000);
		send_sample(LoadMin, 24'sd0);
		send_sample(LoadMax, 24'sd1);
		send_sample(-24'sd1, LoadMin);
		drain();

		s.instant_ratio = '1;
		s.instant_ticks = '1;
		s.control_ratio = '0;
		s.control_ticks = '1;
		s.alarm_ratio   = '0;
		s.slow_weight   = LoadMax;
		s.slow_ticks    = '1;
		apply_setting(s);
		send_sample(24'sd1, 24'sd5);
		send_sample(LoadMax, LoadMin);
		send_sample(24'sd0, 24'sd0);
		drain();

		// long overload run: drive every counter into saturation
		s.instant_ratio = 12'd1024;
		s.instant_ticks = '1;
		s.control_ratio = 12'd512;
		s.control_ticks = '1;
		s.alarm_ratio   = 12'd922;
		s.slow_weight   = '0;
		s.slow_ticks    = 8'd254;
		apply_setting(s);
		for (i = 0; i < 300; i++) begin
			r = LoadW'($urandom_range(1, 1000));
			send_sample(LoadW'(2 * r + 1), r);
		end
		for (i = 0; i < 20; i++) begin
			r = LoadW'($urandom_range(1, 1000));
			send_sample(r, r);
		end
		drain();

		for (regime = 0; regime < 3; regime++) begin
			src_idle_pct = src_plan[regime];
			snk_idle_pct = snk_plan[regime];
			for (k = 0; k < 4; k++) begin
				apply_setting(random_setting());
				if (regime == 2 && k == 1)
					hold_request = 1'b1;
				run_random(110);
				drain();
			end
		end

		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
